### sv/h264afs_pkg.sv
package h264afs_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HOLD_DEPTH = 4;
  localparam int unsigned MAX_BURST  = 5;
  localparam int unsigned Q_DEPTH    = 8;
  localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] NAL_TYPE_MASK      = 8'h1F;
  localparam logic [7:0] SC_LAST_BYTE       = 8'h01;
  localparam logic [4:0] LAST_SLICE_TYPE    = 5'd5;
  localparam logic [4:0] END_OF_SEQ_TYPE    = 5'd10;
  localparam logic [4:0] END_OF_STREAM_TYPE = 5'd11;

  // words produced by one input byte
  typedef struct packed {
    logic [2:0]            cnt;
    logic [4:0][7:0]       data;
    logic [4:0]            last;
  } burst_t;

  function automatic logic closes_frame(input logic [7:0] hdr);
    logic [4:0] t;
    t = 5'(hdr & NAL_TYPE_MASK);
    return (t >= 5'd1 && t <= LAST_SLICE_TYPE) || t == END_OF_SEQ_TYPE ||
           t == END_OF_STREAM_TYPE;
  endfunction

endpackage

### sv/h264afs_core.sv
module h264afs_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [7:0]            in_byte,
  input  logic                  stream_end,
  output h264afs_pkg::burst_t   burst
);

  logic [3:0][7:0] delay_bytes, delay_bytes_next;
  logic [2:0]      held_count, held_count_next;
  logic            synced, synced_next;
  logic            header_next, header_next_next;
  logic            frame_closing, frame_closing_next;

  logic            fc_eff;
  logic            is_sc3, is_sc4, is_sc;
  logic [2:0]      k;
  h264afs_pkg::burst_t b;

  always_comb begin
    fc_eff = frame_closing |
             (synced & header_next & h264afs_pkg::closes_frame(in_byte));
    is_sc3 = (held_count == 3'd3) && delay_bytes[0] == 8'h00 &&
             delay_bytes[1] == 8'h00 && delay_bytes[2] == 8'h00 &&
             in_byte == h264afs_pkg::SC_LAST_BYTE;
    is_sc4 = (held_count == 3'd4) && delay_bytes[1] == 8'h00 &&
             delay_bytes[2] == 8'h00 && delay_bytes[3] == 8'h00 &&
             in_byte == h264afs_pkg::SC_LAST_BYTE;
    is_sc  = is_sc3 | is_sc4;

    delay_bytes_next   = delay_bytes;
    held_count_next    = held_count;
    synced_next        = synced;
    header_next_next   = header_next;
    frame_closing_next = frame_closing;
    b    = '0;
    k    = 3'd0;

    if (is_sc) begin
      if (synced && is_sc4) begin
        b.data[k] = delay_bytes[0];
        b.last[k] = fc_eff;
        k = k + 3'd1;
      end
      b.data[k] = 8'h00; k = k + 3'd1;
      b.data[k] = 8'h00; k = k + 3'd1;
      b.data[k] = 8'h00; k = k + 3'd1;
      b.data[k] = in_byte; k = k + 3'd1;
      frame_closing_next = 1'b0;
      synced_next        = 1'b1;
      header_next_next   = 1'b1;
      held_count_next    = 3'd0;
    end else begin
      header_next_next   = synced ? 1'b0 : header_next;
      frame_closing_next = fc_eff;
      if (held_count[2]) begin
        if (synced) begin
          b.data[k] = delay_bytes[0];
          k = k + 3'd1;
        end
        delay_bytes_next = {in_byte, delay_bytes[3], delay_bytes[2], delay_bytes[1]};
        held_count_next  = 3'd4;
      end else begin
        delay_bytes_next[held_count[1:0]] = in_byte;
        held_count_next = held_count + 3'd1;
      end
    end

    if (stream_end) begin
      if (synced_next) begin
        for (int i = 0; i < h264afs_pkg::HOLD_DEPTH; i++) begin
          if (3'(i) < held_count_next) begin
            b.data[k] = delay_bytes_next[i];
            k = k + 3'd1;
          end
        end
        if (k != 3'd0) begin
          b.last[k - 3'd1] = 1'b1;
        end
      end
      delay_bytes_next   = '0;
      held_count_next    = 3'd0;
      synced_next        = 1'b0;
      header_next_next   = 1'b0;
      frame_closing_next = 1'b0;
    end

    b.cnt = fire ? k : 3'd0;
    burst = b;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      delay_bytes <= delay_bytes_next;
    end
    if (rst) begin
      held_count    <= 3'd0;
      synced        <= 1'b0;
      header_next   <= 1'b0;
      frame_closing <= 1'b0;
    end else if (fire) begin
      held_count    <= held_count_next;
      synced        <= synced_next;
      header_next   <= header_next_next;
      frame_closing <= frame_closing_next;
    end
  end

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held_count <= 3'd4)
    else $error("held count out of range");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && stream_end |=> !synced && held_count == 3'd0 && !frame_closing)
    else $error("state not cleared after stream end");

  a_header_synced: assert property (@(posedge clk) disable iff (rst)
    header_next |-> synced)
    else $error("header pending while unsynced");

endmodule

### sv/h264afs_queue.sv
module h264afs_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  h264afs_pkg::burst_t  burst,
  output logic                 room,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [7:0] out_byte
  output logic                 m_tlast    // frame_last
);

  localparam int unsigned DEPTH = h264afs_pkg::Q_DEPTH;
  localparam int unsigned PW    = h264afs_pkg::Q_PTR_W;
  localparam int unsigned CW    = h264afs_pkg::Q_CNT_W;

  logic [7:0]    data [DEPTH];
  logic          last [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count, count_next;
  logic          pop;

  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = data[rptr];
  assign m_tlast  = last[rptr];
  assign room     = (count <= CW'(DEPTH - h264afs_pkg::MAX_BURST));

  always_comb begin
    count_next = count + CW'(burst.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < h264afs_pkg::MAX_BURST; j++) begin
      if (3'(j) < burst.cnt) begin
        data[wptr + PW'(j)] <= burst.data[j];
        last[wptr + PW'(j)] <= burst.last[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PW'(burst.cnt);
      rptr  <= rptr + PW'(pop);
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue overflow");

  a_push_when_room: assert property (@(posedge clk) disable iff (rst)
    burst.cnt != 3'd0 |-> room)
    else $error("burst written without room");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + CW'($past(burst.cnt)) - CW'($past(pop)))
    else $error("queue count mismatch");

endmodule

### sv/h264_annexb_frame_splitter.sv
// H.264 Annex B frame splitter.
// Slave side takes the byte stream one word per handshake: s_tdata carries
// the stream byte, s_tlast marks the final byte of the stream. Master side
// gives the bytes that belong to frames, start codes included; m_tlast marks
// the final byte of each frame. Bytes ahead of the first 00 00 00 01 are
// dropped. A frame closes at the start code following a slice or end
// NAL unit (types 1-5, 10, 11).
// A byte waits in a four-byte delay line until its fate is known, so output
// lags input by up to four accepted bytes; at stream end the line is flushed.
// One byte is accepted per cycle while s_tready is high. Each byte writes up
// to five words into an eight-word output queue that drains one word per
// cycle while m_tready is high; s_tready falls while the queue holds more
// than three words, which is the only limit on input rate. A stalled
// receiver fills the queue and then stops input.
// Reset (rst, synchronous) empties the queue and returns to the unsynced state.
module h264_annexb_frame_splitter (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // stream_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast    // frame_last
);

  h264afs_pkg::burst_t burst;
  logic                room;
  logic                fire;

  assign s_tready = room;
  assign fire     = s_tvalid && room;

  h264afs_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .in_byte    (s_tdata),
    .stream_end (s_tlast),
    .burst      (burst)
  );

  h264afs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .burst    (burst),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### tb/tb.sv
module tb;

  localparam int CLK_HALF   = 6;
  localparam int CYCLE_MAX  = 200000;
  localparam int MAX_SHOWN  = 10;
  localparam int DRAIN_WAIT = 20;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  // predictor state
  logic [7:0]  held_q[$];
  logic        in_sync;
  logic        hdr_due;
  logic        closing;
  frame_word_t frame_q[$];

  int  errors;
  int  cycles;
  int  bytes_sent;
  int  hold_left;
  int  stall_left;
  bit  tx_calm;
  bit  rx_calm;
  frame_word_t got_w;

  h264_annexb_frame_splitter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic bit is_closing_type(input logic [7:0] hdr);
    logic [4:0] t;
    t = hdr[4:0];
    return (t >= 5'd1 && t <= h264afs_pkg::LAST_SLICE_TYPE) ||
           t == h264afs_pkg::END_OF_SEQ_TYPE ||
           t == h264afs_pkg::END_OF_STREAM_TYPE;
  endfunction

  function automatic void clear_splitter();
    held_q.delete();
    in_sync = 1'b0;
    hdr_due = 1'b0;
    closing = 1'b0;
  endfunction

  function automatic void push_word(input logic [7:0] d, input logic l);
    frame_word_t w;
    w.data = d;
    w.last = l;
    frame_q.push_back(w);
  endfunction

  // expected words caused by one accepted stream byte
  function automatic void split_byte(input logic [7:0] b, input logic stream_end);
    logic [7:0] win[$];
    int n;
    int first_new;
    bit sc;
    first_new = frame_q.size();
    win = held_q;
    win.push_back(b);
    n = win.size();
    if (in_sync && hdr_due) begin
      hdr_due = 1'b0;
      if (is_closing_type(b)) closing = 1'b1;
    end
    sc = n >= 4 && win[n-4] == 8'h00 && win[n-3] == 8'h00 && win[n-2] == 8'h00 &&
         win[n-1] == h264afs_pkg::SC_LAST_BYTE;
    if (sc) begin
      if (in_sync) begin
        for (int i = 0; i < n - 4; i++) push_word(win[i], (i == n - 5) ? closing : 1'b0);
      end
      for (int i = n - 4; i < n; i++) push_word(win[i], 1'b0);
      closing = 1'b0;
      in_sync = 1'b1;
      hdr_due = 1'b1;
      held_q.delete();
    end else begin
      if (n == h264afs_pkg::HOLD_DEPTH + 1) begin
        if (in_sync) push_word(win[0], 1'b0);
        void'(win.pop_front());
      end
      held_q = win;
    end
    if (stream_end) begin
      if (in_sync) begin
        foreach (held_q[i]) push_word(held_q[i], 1'b0);
        if (frame_q.size() > first_new) frame_q[frame_q.size()-1].last = 1'b1;
      end
      clear_splitter();
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic note_mismatch(input string what, input logic [7:0] ed, input logic el,
                               input logic [7:0] ad, input logic al);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("mismatch (%s): expected %02h last %0b, got %02h last %0b",
               what, ed, el, ad, al);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic stream_end);
    int g;
    g = tx_calm ? 0 : gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= stream_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    split_byte(b, stream_end);
    bytes_sent++;
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
  endtask

  function automatic logic [7:0] pick_header();
    int idx;
    logic [4:0] t;
    if ($urandom_range(0, 1)) begin
      idx = $urandom_range(0, 6);
      t = (idx < 5) ? 5'(idx + 1) :
          (idx == 5 ? h264afs_pkg::END_OF_SEQ_TYPE : h264afs_pkg::END_OF_STREAM_TYPE);
    end else begin
      t = 5'($urandom_range(0, 31));
    end
    return {3'($urandom_range(0, 7)), t};
  endfunction

  function automatic logic [7:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'h00;
    if (r < 45) return h264afs_pkg::SC_LAST_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  // a whole stream: optional junk, then NAL units; broken ones get damaged codes
  task automatic send_stream(input bit broken, input int max_payload);
    logic [7:0] s[$];
    repeat ($urandom_range(0, 3)) s.push_back(pick_payload());
    repeat ($urandom_range(1, 4)) begin
      if (broken && $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) s.push_back(8'h00);
        s.push_back($urandom_range(0, 1) ? h264afs_pkg::SC_LAST_BYTE :
                    8'($urandom_range(2, 255)));
      end else begin
        s.push_back(8'h00); s.push_back(8'h00); s.push_back(8'h00);
        s.push_back(h264afs_pkg::SC_LAST_BYTE);
      end
      s.push_back(pick_header());
      repeat ($urandom_range(0, max_payload)) s.push_back(pick_payload());
    end
    send_seq(s);
  endtask

  task automatic wait_drained();
    while (frame_q.size() != 0) @(posedge clk);
  endtask

  // junk ahead of sync, stream end before sync, three-byte code as junk
  task automatic test_presync_drop();
    send_seq('{8'hAA, 8'h00, 8'h00, h264afs_pkg::SC_LAST_BYTE, 8'hFF});
    send_seq('{8'h00, 8'h00});
  endtask

  // header that starts a start code, slice closing a frame, end on start code,
  // end-of-stream type, three-byte code inside payload
  task automatic test_frame_edges();
    send_seq('{8'h00, 8'h00, 8'h00, h264afs_pkg::SC_LAST_BYTE,
               8'h00, 8'h00, 8'h00, h264afs_pkg::SC_LAST_BYTE,
               8'h65, 8'h80, 8'h00, 8'h00, 8'h00, h264afs_pkg::SC_LAST_BYTE});
    send_seq('{8'h00, 8'h00, 8'h00, h264afs_pkg::SC_LAST_BYTE, 8'h2B, 8'hFF, 8'h00,
               8'h00, h264afs_pkg::SC_LAST_BYTE, 8'h7E});
  endtask

  task automatic test_random_streams(input int upto);
    while (bytes_sent < upto) send_stream($urandom_range(0, 4) == 0, 8);
  endtask

  task automatic test_back_to_back(input int upto);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    while (bytes_sent < upto) send_stream(1'b0, 6);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_output_hold();
    logic [7:0] s[$];
    tx_calm = 1'b1;
    hold_left = 150;
    s = '{8'h00, 8'h00, 8'h00, h264afs_pkg::SC_LAST_BYTE, 8'h41};
    repeat (30) s.push_back(8'($urandom_range(1, 255)));
    s.push_back(8'h00); s.push_back(8'h00); s.push_back(8'h00);
    s.push_back(h264afs_pkg::SC_LAST_BYTE);
    s.push_back(8'h25);
    send_seq(s);
    tx_calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (!rx_calm && $urandom_range(0, 99) < 20) begin
      m_tready <= 1'b0;
      stall_left = gap_len();
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (frame_q.size() == 0) begin
        note_mismatch("no word expected", 8'h00, 1'b0, m_tdata, m_tlast);
      end else begin
        got_w = frame_q.pop_front();
        if (m_tdata !== got_w.data)
          note_mismatch("tdata", got_w.data, got_w.last, m_tdata, m_tlast);
        if (m_tlast !== got_w.last)
          note_mismatch("tlast", got_w.data, got_w.last, m_tdata, m_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_MAX) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    bytes_sent = 0;
    hold_left = 0;
    stall_left = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    clear_splitter();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_presync_drop();
    test_frame_edges();
    test_random_streams(110);
    test_back_to_back(145);
    test_output_hold();
    test_random_streams(215);

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (frame_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
